// ===== src/lhd_pkg.sv =====
// ---------------------------------------------------------------------------
// lhd_pkg
// shared types, codes and helpers of the layered heat diffusion block
// ---------------------------------------------------------------------------
package lhd_pkg;

  localparam int MAX_CELLS_DEF  = 64;
  localparam int MAX_LAYERS_DEF = 4;

  localparam int T_W   = 24;
  localparam int DIV_W = 24;

  localparam logic signed [T_W-1:0] T_MAX     = 24'sh7fffff;
  localparam logic signed [T_W-1:0] T_MIN     = 24'sh800000;
  localparam logic signed [T_W-1:0] TINIT_RST = 24'sd6400;
  localparam logic [15:0]           COND_ONE  = 16'd256;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_STEP = 2'd1,
    OP_LOAD = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_LAYER_COUNT = 3'd0,
    CFG_HEAT_JUMP   = 3'd1,
    CFG_PERIOD_CNT  = 3'd2,
    CFG_PERIOD_LEN  = 3'd3,
    CFG_HEAT_OFFSET = 3'd4,
    CFG_HEAT_LEN    = 3'd5,
    CFG_INIT_TEMP   = 3'd6
  } cfg_e;

  typedef struct packed {
    logic               start;
    logic [2*DIV_W-1:0] dividend;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  function automatic logic signed [T_W-1:0] sat_t(input logic signed [28:0] v);
    logic signed [T_W-1:0] r;
    if (v > 29'(T_MAX)) r = T_MAX;
    else if (v < 29'(T_MIN)) r = T_MIN;
    else r = T_W'(v);
    return r;
  endfunction

  function automatic logic is_sat(input logic signed [28:0] v);
    return (v > 29'(T_MAX)) || (v < 29'(T_MIN));
  endfunction

endpackage

// ===== src/lhd_ram.sv =====
// ---------------------------------------------------------------------------
// lhd_ram
// profile store, one write port and one registered read port
// ---------------------------------------------------------------------------
module lhd_ram import lhd_pkg::*; #(
  parameter int DEPTH = MAX_CELLS_DEF,
  parameter int WIDTH = T_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/lhd_div.sv =====
// ---------------------------------------------------------------------------
// lhd_div
// restoring divider, one quotient bit per cycle; upper dividend half below divisor
// ---------------------------------------------------------------------------
module lhd_div import lhd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(DIV_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DIV_W-1:0] r_q, lo_q, dvs_q;
  logic [DIV_W:0]   trial, diff;
  logic             qbit;

  assign trial = {r_q, lo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= req_i.dividend[2*DIV_W-1:DIV_W];
      lo_q  <= req_i.dividend[DIV_W-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      r_q  <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      lo_q <= {lo_q[DIV_W-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = lo_q;
  assign rsp_o.rem  = r_q;

endmodule

// ===== src/layered_heat_diffusion_step.sv =====
// ---------------------------------------------------------------------------
// layered_heat_diffusion_step
// explicit ftcs step of a layered 1-d temperature profile held in a ram
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid_i/in_ready_o | operation and its operands
//  out     | output    | out_valid_o/out_ready_i| temperature, heating, status
//  cfg     | input     | cfg_valid_i/cfg_ready_o| register index and data
//
//  a step is paced by the cell sweep through the single ram read port
//  and by the bit-serial divider (heating window, where that division is
//  needed, and each interface mean); a step with a bad profile ends
//  after the layer setup and the check, with no sweep
//  reset: a clearing pass writes zero to all MAX_CELLS cells, during
//  which no word is accepted; config is always taken
//  stalls: one finished word waits in the output register while the next
//  word is accepted; a further result holds until that slot frees
// ---------------------------------------------------------------------------
module layered_heat_diffusion_step import lhd_pkg::*; #(
  parameter int MAX_CELLS  = MAX_CELLS_DEF,
  parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [23:0]        time_step_i,
  input  logic [5:0]         cell_index_i,
  input  logic [1:0]         layer_index_i,
  input  logic [6:0]         layer_cells_i,
  input  logic [15:0]        layer_factor_i,
  input  logic [15:0]        layer_conductivity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] temperature_o,
  output logic               heating_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int NLW   = $clog2(MAX_LAYERS + 1);
  localparam int CNT_W = $clog2(MAX_LAYERS * 128 + MAX_CELLS + 1);

  typedef enum logic [16:0] {
    S_CLEAR   = 17'b00000000000000001,
    S_IDLE    = 17'b00000000000000010,
    S_FILL    = 17'b00000000000000100,
    S_RWAIT   = 17'b00000000000001000,
    S_SETUP   = 17'b00000000000010000,
    S_CHECK   = 17'b00000000000100000,
    S_HDIV    = 17'b00000000001000000,
    S_STEN    = 17'b00000000010000000,
    S_EDGE_R  = 17'b00000000100000000,
    S_EDGE_L  = 17'b00000001000000000,
    S_IF_NEXT = 17'b00000010000000000,
    S_IF_CHK  = 17'b00000100000000000,
    S_IF_RA   = 17'b00001000000000000,
    S_IF_RB   = 17'b00010000000000000,
    S_IF_SUM  = 17'b00100000000000000,
    S_IF_WAIT = 17'b01000000000000000,
    S_FIN     = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [2:0]            lc_q;
  logic [22:0]           jump_q;
  logic [15:0]           pc_q;
  logic [23:0]           plen_q, hoff_q, hlen_q;
  logic signed [T_W-1:0] tinit_q;

  // layer tables
  logic [6:0]  cells_tab [MAX_LAYERS];
  logic [15:0] fac_tab   [MAX_LAYERS];
  logic [15:0] cond_tab  [MAX_LAYERS];

  // ram ports
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic signed [T_W-1:0] ram_wdata, ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // sequencing
  logic [AW-1:0]     fill_q;
  logic [LW-1:0]     sl_q, l_q, lay, cell_sel, cond_sel;
  logic [CNT_W-1:0]  acc_q, n_q, s_q, rd_idx_q, rcell_q;
  logic [CNT_W-1:0]  bnd_q [MAX_LAYERS];
  logic [NLW-1:0]    nl;
  logic [6:0]        cells_rd;
  logic [15:0]       cond_rd;
  logic              rd_more, n_bad, heat_skip, s_ok, if_last, ci_ok;

  // stencil pipeline
  logic                  rdv_q, v1_q, v2_q;
  logic signed [T_W-1:0] w1_q, w2_q, ctr1_q, ctr2_q, nx1_q, nxn2_q;
  logic signed [26:0]    diff_q, diff_d;
  logic [15:0]           fac1_q;
  logic [CNT_W-1:0]      x1_q, x2_q;
  logic signed [43:0]    prod_q, prod_d, rnd;
  logic signed [28:0]    sten_sum, edge_sum;
  logic signed [T_W-1:0] sten_val, edge_val;
  logic                  sat_q, heat_q;

  // heating window
  logic [23:0] tstep_q, dlt, dlt_q, hval;
  logic [39:0] pm_q;

  // interface mean
  logic [15:0]           k1_q, ke1, ke2;
  logic signed [T_W-1:0] a_q;
  logic signed [40:0]    p1_q, p2_q, p1_d, p2_d;
  logic [16:0]           den_q;
  logic signed [41:0]    num;
  logic signed [43:0]    n2, xdiv;
  logic                  kz;

  // result staging and output register
  logic signed [T_W-1:0] res_temp_q, temp_q;
  logic                  res_heat_q, heatout_q;
  logic [1:0]            res_stat_q, stat_q;
  logic                  out_valid_q;
  logic                  out_load;

  lhd_ram #(.DEPTH(MAX_CELLS), .WIDTH(T_W), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lhd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // layers in use, clipped to one..MAX_LAYERS
  always_comb begin
    if (lc_q == 3'd0) nl = NLW'(1);
    else if (int'(lc_q) > MAX_LAYERS) nl = NLW'(MAX_LAYERS);
    else nl = NLW'(lc_q);
  end

  // layer of the newest cell in the window: boundaries at or below it
  always_comb begin
    lay = '0;
    for (int l = 0; l < MAX_LAYERS; l++) begin
      if (bnd_q[l] <= rcell_q) lay = lay + LW'(1);
    end
  end

  assign cell_sel = (state_q == S_SETUP) ? sl_q : l_q;
  assign cells_rd = cells_tab[cell_sel];
  assign cond_sel = (state_q == S_IF_RA) ? l_q : LW'(l_q + LW'(1));
  assign cond_rd  = cond_tab[cond_sel];

  assign ci_ok     = int'(cell_index_i) < MAX_CELLS;
  assign n_bad     = (n_q < CNT_W'(3)) || (n_q > CNT_W'(MAX_CELLS));
  assign heat_skip = (pc_q == 16'd0) || (tstep_q < hoff_q);
  assign dlt       = tstep_q - hoff_q;
  assign rd_more   = rd_idx_q < n_q;
  assign s_ok      = (s_q >= CNT_W'(1)) && (s_q <= n_q - CNT_W'(2));
  assign if_last   = int'(l_q) >= int'(nl) - 1;

  // stencil arithmetic, window is old[j-2], old[j-1], old[j]
  assign diff_d   = 27'(ram_rdata) - (27'(w1_q) <<< 1) + 27'(w2_q);
  assign prod_d   = diff_q * $signed({1'b0, fac1_q});
  assign rnd      = prod_q + 44'sd32768;
  assign sten_sum = 29'(ctr2_q) + 29'($signed(rnd[43:16]));
  assign sten_val = sat_t(sten_sum);

  // right edge, plus the jump inside a heating window
  assign edge_sum = 29'(nxn2_q) + (heat_q ? $signed({6'b0, jump_q}) : 29'sd0);
  assign edge_val = sat_t(edge_sum);

  // interface weights; both zero falls back to the plain mean
  assign kz   = (k1_q == 16'd0) && (cond_rd == 16'd0);
  assign ke1  = kz ? 16'd1 : k1_q;
  assign ke2  = kz ? 16'd1 : cond_rd;
  assign p1_d = $signed({1'b0, ke1}) * a_q;
  assign p2_d = $signed({1'b0, ke2}) * ram_rdata;
  assign num  = 42'(p1_q) + 42'(p2_q);
  // floor((2num+den)/(2den)) biased by 2^23 so the dividend stays positive
  assign n2   = (44'(num) <<< 1) + $signed({27'b0, den_q});
  assign xdiv = n2 + $signed({2'b0, den_q, 24'b0});

  // heating window remainder, clamped to the last period
  assign hval = (div_rsp.quo >= 24'(pc_q)) ? (dlt_q - pm_q[23:0]) : div_rsp.rem;

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    div_req   = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        if (fill_q == AW'(MAX_CELLS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(operation_i))
            OP_FILL: state_d = S_FILL;
            OP_STEP: state_d = S_SETUP;
            OP_LOAD: state_d = S_FIN;
            OP_READ: begin
              if (ci_ok) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cell_index_i);
                state_d   = S_RWAIT;
              end else begin
                state_d = S_FIN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        ram_wdata = tinit_q;
        if (fill_q == AW'(MAX_CELLS - 1)) state_d = S_FIN;
      end
      S_RWAIT: state_d = S_FIN;
      S_SETUP: begin
        if (sl_q == LW'(MAX_LAYERS - 1)) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (n_bad) begin
          state_d = S_FIN;
        end else if (heat_skip || (plen_q == 24'd0)) begin
          state_d = S_STEN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {24'b0, dlt};
          div_req.divisor  = plen_q;
          state_d          = S_HDIV;
        end
      end
      S_HDIV: begin
        if (div_rsp.done) state_d = S_STEN;
      end
      S_STEN: begin
        ram_re    = rd_more;
        ram_raddr = rd_idx_q[AW-1:0];
        if (v2_q) begin
          ram_we    = 1'b1;
          ram_waddr = x2_q[AW-1:0];
          ram_wdata = sten_val;
        end
        if (!rd_more && !rdv_q && !v1_q && !v2_q) state_d = S_EDGE_R;
      end
      S_EDGE_R: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(n_q - CNT_W'(1));
        ram_wdata = edge_val;
        state_d   = S_EDGE_L;
      end
      S_EDGE_L: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = nx1_q;
        state_d   = S_IF_NEXT;
      end
      S_IF_NEXT: state_d = if_last ? S_FIN : S_IF_CHK;
      S_IF_CHK: begin
        if (s_ok) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(s_q - CNT_W'(1));
          state_d   = S_IF_RA;
        end else begin
          state_d = S_IF_NEXT;
        end
      end
      S_IF_RA: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(s_q + CNT_W'(1));
        state_d   = S_IF_RB;
      end
      S_IF_RB: state_d = S_IF_SUM;
      S_IF_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = {5'b0, xdiv[42:0]};
        div_req.divisor  = {6'b0, den_q, 1'b0};
        state_d          = S_IF_WAIT;
      end
      S_IF_WAIT: begin
        if (div_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(s_q);
          ram_wdata = {~div_rsp.quo[23], div_rsp.quo[22:0]};
          state_d   = S_IF_NEXT;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state, configuration and layer tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fill_q      <= '0;
      sl_q        <= '0;
      l_q         <= '0;
      rd_idx_q    <= '0;
      rdv_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      lc_q        <= 3'd1;
      jump_q      <= '0;
      pc_q        <= '0;
      plen_q      <= '0;
      hoff_q      <= '0;
      hlen_q      <= '0;
      tinit_q     <= TINIT_RST;
      for (int l = 0; l < MAX_LAYERS; l++) begin
        cells_tab[l] <= '0;
        fac_tab[l]   <= '0;
        cond_tab[l]  <= COND_ONE;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_LAYER_COUNT: lc_q    <= cfg_data_i[2:0];
          CFG_HEAT_JUMP:   jump_q  <= cfg_data_i[22:0];
          CFG_PERIOD_CNT:  pc_q    <= cfg_data_i[15:0];
          CFG_PERIOD_LEN:  plen_q  <= cfg_data_i;
          CFG_HEAT_OFFSET: hoff_q  <= cfg_data_i;
          CFG_HEAT_LEN:    hlen_q  <= cfg_data_i;
          CFG_INIT_TEMP:   tinit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // layer entry load at acceptance
      if (in_valid_i && in_ready_o && (op_e'(operation_i) == OP_LOAD)
          && (int'(layer_index_i) < MAX_LAYERS)) begin
        cells_tab[LW'(layer_index_i)] <= layer_cells_i;
        fac_tab[LW'(layer_index_i)]   <= layer_factor_i;
        cond_tab[LW'(layer_index_i)]  <= layer_conductivity_i;
      end

      if ((state_q == S_CLEAR) || (state_q == S_FILL)) begin
        fill_q <= (fill_q == AW'(MAX_CELLS - 1)) ? '0 : fill_q + AW'(1);
      end

      if (in_valid_i && in_ready_o) sl_q <= '0;
      else if (state_q == S_SETUP) sl_q <= sl_q + LW'(1);

      if (state_q == S_CHECK) rd_idx_q <= '0;
      else if ((state_q == S_STEN) && rd_more) rd_idx_q <= rd_idx_q + CNT_W'(1);

      if (state_q == S_STEN) begin
        rdv_q <= rd_more;
        v1_q  <= rdv_q && (rcell_q >= CNT_W'(2));
        v2_q  <= v1_q;
      end else begin
        rdv_q <= 1'b0;
        v1_q  <= 1'b0;
        v2_q  <= 1'b0;
      end

      if (state_q == S_EDGE_L) l_q <= '0;
      else if (((state_q == S_IF_CHK) && !s_ok) || ((state_q == S_IF_WAIT) && div_rsp.done))
        l_q <= l_q + LW'(1);

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tstep_q    <= time_step_i;
      acc_q      <= '0;
      n_q        <= '0;
      res_temp_q <= '0;
      res_heat_q <= 1'b0;
      res_stat_q <= (((op_e'(operation_i) == OP_LOAD) && (int'(layer_index_i) >= MAX_LAYERS))
                     || ((op_e'(operation_i) == OP_READ) && !ci_ok)) ? STAT_RANGE : STAT_OK;
    end

    if (state_q == S_RWAIT) res_temp_q <= ram_rdata;

    // prefix sums of the cell counts, total over the layers in use
    if (state_q == S_SETUP) begin
      acc_q       <= acc_q + CNT_W'(cells_rd);
      bnd_q[sl_q] <= acc_q + CNT_W'(cells_rd);
      if (int'(sl_q) < int'(nl)) n_q <= n_q + CNT_W'(cells_rd);
    end

    if (state_q == S_CHECK) begin
      sat_q  <= 1'b0;
      heat_q <= !n_bad && !heat_skip && (plen_q == 24'd0) && (dlt <= hlen_q);
      dlt_q  <= dlt;
      pm_q   <= (pc_q - 16'd1) * plen_q;
      if (n_bad) res_stat_q <= STAT_RANGE;
    end

    if ((state_q == S_HDIV) && div_rsp.done) heat_q <= hval <= hlen_q;

    // stencil pipeline
    rcell_q <= rd_idx_q;
    if (rdv_q) begin
      w2_q   <= w1_q;
      w1_q   <= ram_rdata;
      diff_q <= diff_d;
      ctr1_q <= w1_q;
      x1_q   <= rcell_q - CNT_W'(1);
      fac1_q <= fac_tab[lay];
    end
    if (v1_q) begin
      prod_q <= prod_d;
      ctr2_q <= ctr1_q;
      x2_q   <= x1_q;
    end
    if (v2_q) begin
      if (x2_q == CNT_W'(1)) nx1_q <= sten_val;
      if (x2_q == n_q - CNT_W'(2)) nxn2_q <= sten_val;
      if (is_sat(sten_sum)) sat_q <= 1'b1;
    end

    if ((state_q == S_EDGE_R) && heat_q && is_sat(edge_sum)) sat_q <= 1'b1;

    // interface walk
    if (state_q == S_EDGE_L) s_q <= '0;
    else if ((state_q == S_IF_NEXT) && !if_last) s_q <= s_q + CNT_W'(cells_rd);

    if ((state_q == S_IF_NEXT) && if_last) begin
      res_heat_q <= heat_q;
      res_stat_q <= sat_q ? STAT_SAT : STAT_OK;
    end

    if (state_q == S_IF_RA) begin
      a_q  <= ram_rdata;
      k1_q <= cond_rd;
    end
    if (state_q == S_IF_RB) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      den_q <= 17'(ke1) + 17'(ke2);
    end

    // output register
    if (out_load) begin
      temp_q    <= res_temp_q;
      heatout_q <= res_heat_q;
      stat_q    <= res_stat_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = temp_q;
  assign heating_o     = heatout_q;
  assign status_o      = stat_q;

endmodule
